### src/lewt_pkg.sv
// Shared constants, types and the character classifier for the line editor.
package lewt_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;

  localparam int CHAR_W    = 7;
  localparam int TMO_W     = 24;
  localparam int CAP_W     = 6;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 24'd240000;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

  // Characters with a special meaning.
  localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;
  localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_CTRL_R = 7'h12;
  localparam logic [CHAR_W-1:0] CH_CTRL_U = 7'h15;
  localparam logic [CHAR_W-1:0] CH_CTRL_W = 7'h17;
  localparam logic [CHAR_W-1:0] CH_SP     = 7'h20;
  localparam logic [CHAR_W-1:0] CH_HASH   = 7'h23;
  localparam logic [CHAR_W-1:0] CH_AT     = 7'h40;
  localparam logic [CHAR_W-1:0] CH_DEL    = 7'h7F;

  // Character classes.
  localparam logic [2:0] CLS_STORE   = 3'd0;
  localparam logic [2:0] CLS_NEWLINE = 3'd1;
  localparam logic [2:0] CLS_ERASE   = 3'd2;
  localparam logic [2:0] CLS_SILENT  = 3'd3;
  localparam logic [2:0] CLS_REPRINT = 3'd4;
  localparam logic [2:0] CLS_KILL    = 3'd5;

  // Line end status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Sources of an emitted result.
  localparam logic [2:0] SRC_LF       = 3'd0;
  localparam logic [2:0] SRC_BS       = 3'd1;
  localparam logic [2:0] SRC_SP       = 3'd2;
  localparam logic [2:0] SRC_CHAR     = 3'd3;
  localparam logic [2:0] SRC_MEM_ECHO = 3'd4;
  localparam logic [2:0] SRC_MEM_LINE = 3'd5;
  localparam logic [2:0] SRC_END      = 3'd6;

  // Read limit selection.
  localparam logic [1:0] LEN_ZERO  = 2'd0;
  localparam logic [1:0] LEN_COUNT = 2'd1;
  localparam logic [1:0] LEN_CAPM1 = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       idle_inc;
    logic       set_first;
    logic       dec;
    logic       clear_count;
    logic       store;
    logic       load_lim;
    logic [1:0] len_sel;
    logic       set_status;
    logic [1:0] end_status;
    logic       rd_issue;
    logic       rd_next;
    logic       emit;
    logic [2:0] src;
    logic       last;
    logic       clear_line;
  } cmd_t;

  typedef struct packed {
    logic       idle_like;
    logic       is_tick;
    logic [2:0] cls;
    logic       count_zero;
    logic       idle_hit;
    logic       store_ovf;
    logic       rd_done;
    logic       rd_final;
    logic       out_free;
  } stat_t;

  function automatic logic [2:0] char_class(input logic [CHAR_W-1:0] c);
    logic [2:0] r;
    case (c)
      CH_LF, CH_CR:                r = CLS_NEWLINE;
      CH_BS, CH_DEL:               r = CLS_ERASE;
      CH_HASH:                     r = CLS_SILENT;
      CH_CTRL_R:                   r = CLS_REPRINT;
      CH_AT, CH_CTRL_U, CH_CTRL_W: r = CLS_KILL;
      default:                     r = CLS_STORE;
    endcase
    return r;
  endfunction

endpackage

### src/lewt_ctrl.sv
// Sequencing state machine of the line editor.
module lewt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  lewt_pkg::stat_t  st,
  output lewt_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_ECHO_A  = 3'd2;
  localparam logic [2:0] S_ECHO_B  = 3'd3;
  localparam logic [2:0] S_ECHO_C  = 3'd4;
  localparam logic [2:0] S_RD_CHK  = 3'd5;
  localparam logic [2:0] S_RD_EMIT = 3'd6;
  localparam logic [2:0] S_END     = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] op, op_next;
  logic       ovf, ovf_next;
  logic       rd_line, rd_line_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    op      <= op_next;
    ovf     <= ovf_next;
    rd_line <= rd_line_next;
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    op_next      = op;
    ovf_next     = ovf;
    rd_line_next = rd_line;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.idle_like) begin
          cmd.idle_inc = 1'b1;
          if (st.idle_hit) begin
            cmd.load_lim   = 1'b1;
            cmd.len_sel    = lewt_pkg::LEN_ZERO;
            cmd.set_status = 1'b1;
            cmd.end_status = lewt_pkg::ST_TIMEOUT;
            rd_line_next   = 1'b1;
            state_next     = S_RD_CHK;
          end else begin
            state_next = S_IDLE;
          end
        end else if (st.is_tick) begin
          state_next = S_IDLE;
        end else begin
          cmd.set_first = 1'b1;
          op_next       = st.cls;
          state_next    = S_ECHO_A;
          case (st.cls)
            lewt_pkg::CLS_ERASE: begin
              if (st.count_zero) begin
                state_next = S_IDLE;
              end else begin
                cmd.dec = 1'b1;
              end
            end
            lewt_pkg::CLS_SILENT: begin
              cmd.dec    = !st.count_zero;
              state_next = S_IDLE;
            end
            lewt_pkg::CLS_KILL: begin
              cmd.clear_count = 1'b1;
            end
            lewt_pkg::CLS_STORE: begin
              cmd.store = 1'b1;
              ovf_next  = st.store_ovf;
            end
            default: begin
            end
          endcase
        end
      end
      S_ECHO_A: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          case (op)
            lewt_pkg::CLS_NEWLINE: begin
              cmd.src        = lewt_pkg::SRC_LF;
              cmd.load_lim   = 1'b1;
              cmd.len_sel    = lewt_pkg::LEN_COUNT;
              cmd.set_status = 1'b1;
              cmd.end_status = lewt_pkg::ST_OK;
              rd_line_next   = 1'b1;
              state_next     = S_RD_CHK;
            end
            lewt_pkg::CLS_ERASE: begin
              cmd.src    = lewt_pkg::SRC_BS;
              state_next = S_ECHO_B;
            end
            lewt_pkg::CLS_REPRINT: begin
              cmd.src      = lewt_pkg::SRC_LF;
              cmd.last     = st.count_zero;
              cmd.load_lim = 1'b1;
              cmd.len_sel  = lewt_pkg::LEN_COUNT;
              rd_line_next = 1'b0;
              state_next   = S_RD_CHK;
            end
            lewt_pkg::CLS_KILL: begin
              cmd.src    = lewt_pkg::SRC_LF;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end
            default: begin
              cmd.src  = lewt_pkg::SRC_CHAR;
              cmd.last = !ovf;
              if (ovf) begin
                cmd.load_lim   = 1'b1;
                cmd.len_sel    = lewt_pkg::LEN_CAPM1;
                cmd.set_status = 1'b1;
                cmd.end_status = lewt_pkg::ST_OVERFLOW;
                rd_line_next   = 1'b1;
                state_next     = S_RD_CHK;
              end else begin
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      S_ECHO_B: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = lewt_pkg::SRC_SP;
          state_next = S_ECHO_C;
        end
      end
      S_ECHO_C: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = lewt_pkg::SRC_BS;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_CHK: begin
        if (st.rd_done) begin
          state_next = rd_line ? S_END : S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD_EMIT;
        end
      end
      S_RD_EMIT: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = rd_line ? lewt_pkg::SRC_MEM_LINE : lewt_pkg::SRC_MEM_ECHO;
          cmd.last    = !rd_line && st.rd_final;
          cmd.rd_next = 1'b1;
          state_next  = S_RD_CHK;
        end
      end
      S_END: begin
        if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.src        = lewt_pkg::SRC_END;
          cmd.last       = 1'b1;
          cmd.clear_line = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/lewt_dp.sv
// Datapath of the line editor: settings, counters, line buffer and output register.
module lewt_dp #(
  parameter int BUFFER_DEPTH = lewt_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lewt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lewt_pkg::TMO_W-1:0]        cfg_data,
  input  logic                              in_kind,
  input  logic [lewt_pkg::CHAR_W-1:0]       in_char_d,
  input  lewt_pkg::cmd_t                    cmd,
  output lewt_pkg::stat_t                   st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [lewt_pkg::CHAR_W-1:0]       out_byte,
  output logic [1:0]                        out_status,
  output logic [lewt_pkg::LEN_W-1:0]        out_len,
  output logic                              out_last
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int AW    = $clog2(BUFFER_DEPTH);

  logic [lewt_pkg::TMO_W-1:0]  tmo;
  logic [lewt_pkg::CAP_W-1:0]  cap;
  logic                        kind_q;
  logic [lewt_pkg::CHAR_W-1:0] char_q;
  logic [CNT_W-1:0]            count;
  logic [lewt_pkg::TMO_W-1:0]  idle_cnt;
  logic                        got_first;
  logic [CNT_W-1:0]            k;
  logic [CNT_W-1:0]            lim;
  logic [1:0]                  end_status;
  logic [lewt_pkg::CHAR_W-1:0] mem [BUFFER_DEPTH];
  logic [lewt_pkg::CHAR_W-1:0] mem_q;

  logic [lewt_pkg::CAP_W-1:0]  cap_eff;
  logic [lewt_pkg::TMO_W-1:0]  idle_inc;
  logic [CNT_W-1:0]            lim_sel;
  logic [7:0]                  lim_ext;
  logic                        out_free;

  assign cfg_ready = 1'b1;

  // Capacity of zero acts as one, anything above the buffer depth as the depth.
  always_comb begin
    cap_eff = cap;
    if (cap == '0) begin
      cap_eff = lewt_pkg::CAP_W'(1);
    end else if (cap > lewt_pkg::CAP_W'(BUFFER_DEPTH)) begin
      cap_eff = lewt_pkg::CAP_W'(BUFFER_DEPTH);
    end
  end

  assign idle_inc = idle_cnt + 1'b1;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.len_sel)
      lewt_pkg::LEN_COUNT: lim_sel = count;
      lewt_pkg::LEN_CAPM1: lim_sel = CNT_W'(cap_eff - 1'b1);
      default:             lim_sel = '0;
    endcase
  end

  assign lim_ext = 8'(lim);

  assign st.idle_like  = !got_first && (!kind_q || char_q == lewt_pkg::CH_NUL);
  assign st.is_tick    = !kind_q;
  assign st.cls        = lewt_pkg::char_class(char_q);
  assign st.count_zero = (count == '0);
  assign st.idle_hit   = (idle_inc >= tmo);
  assign st.store_ovf  = ((7'(count) + 7'd1) >= 7'(cap_eff));
  assign st.rd_done    = (k == lim);
  assign st.rd_final   = ((7'(k) + 7'd1) == 7'(lim));
  assign st.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo       <= lewt_pkg::TIMEOUT_RESET;
      cap       <= lewt_pkg::CAPACITY_RESET;
      count     <= '0;
      idle_cnt  <= '0;
      got_first <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lewt_pkg::CFG_TIMEOUT) begin
          tmo <= cfg_data;
        end else if (cfg_index == lewt_pkg::CFG_CAPACITY) begin
          cap <= cfg_data[lewt_pkg::CAP_W-1:0];
        end
      end
      if (cmd.idle_inc) begin
        idle_cnt <= idle_inc;
      end
      if (cmd.set_first) begin
        got_first <= 1'b1;
      end
      if (cmd.dec) begin
        count <= count - 1'b1;
      end else if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.store) begin
        count <= count + 1'b1;
      end
      if (cmd.clear_line) begin
        count     <= '0;
        idle_cnt  <= '0;
        got_first <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_q <= in_kind;
      char_q <= in_char_d;
    end
    if (cmd.load_lim) begin
      lim <= lim_sel;
      k   <= '0;
    end else if (cmd.rd_next) begin
      k <= k + 1'b1;
    end
    if (cmd.set_status) begin
      end_status <= cmd.end_status;
    end
    if (cmd.emit) begin
      out_last   <= cmd.last;
      out_status <= 2'b00;
      out_len    <= '0;
      case (cmd.src)
        lewt_pkg::SRC_LF: begin
          out_kind <= lewt_pkg::KIND_ECHO;
          out_byte <= lewt_pkg::CH_LF;
        end
        lewt_pkg::SRC_BS: begin
          out_kind <= lewt_pkg::KIND_ECHO;
          out_byte <= lewt_pkg::CH_BS;
        end
        lewt_pkg::SRC_SP: begin
          out_kind <= lewt_pkg::KIND_ECHO;
          out_byte <= lewt_pkg::CH_SP;
        end
        lewt_pkg::SRC_CHAR: begin
          out_kind <= lewt_pkg::KIND_ECHO;
          out_byte <= char_q;
        end
        lewt_pkg::SRC_MEM_ECHO: begin
          out_kind <= lewt_pkg::KIND_ECHO;
          out_byte <= mem_q;
        end
        lewt_pkg::SRC_MEM_LINE: begin
          out_kind <= lewt_pkg::KIND_LINE;
          out_byte <= mem_q;
        end
        default: begin
          out_kind   <= lewt_pkg::KIND_END;
          out_byte   <= '0;
          out_status <= end_status;
          out_len    <= lim_ext[lewt_pkg::LEN_W-1:0];
        end
      endcase
    end
  end

  // Line buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[AW-1:0]] <= char_q;
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[k[AW-1:0]];
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result emitted while the output register is still occupied");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (7'(count) < 7'(BUFFER_DEPTH)))
    else $error("character stored past the end of the line buffer");

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_line |=> (count == '0) && !got_first && (idle_cnt == '0))
    else $error("line state not cleared after an end marker");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (k < lim))
    else $error("line buffer read beyond the read limit");

endmodule

### src/line_editor_with_timeout.sv
// Top level of the console line editor with idle timeout.
//
// Usage: each request on the slave stream is one input item. s_tuser is the
// item kind (0 idle tick, 1 character) and s_tdata[6:0] the character. The
// block echoes stored characters, applies the erase, silent erase, reprint
// and line kill keys, and ends a line on CR or LF, when it reaches capacity,
// or when the idle tick limit passes before the first character. A finished
// line comes out on the master stream as its bytes and then one end marker.
// m_tlast marks the final result that an input item causes; an item may
// cause none. The configuration channel writes the timeout (index 0) and
// the line capacity (index 1); writes are taken at any time.
// Flow: s_tready is high only while the controller waits for an item.
// An item is taken in and then decoded; each echo result is then emitted,
// and each byte read from the line buffer (one write port, one registered
// read port) goes out as an address step and then a registered data step.
// The single output register holds a result while m_tready is low, and the
// controller waits until it can be refilled; nothing is dropped. Reset
// clears the line, the line and idle counters and the output, and restores
// the settings to their reset values; the line buffer needs no clearing.
module line_editor_with_timeout #(
  parameter int BUFFER_DEPTH = lewt_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,    // [6:0] char_in, [7] zero
  input  logic                           s_tuser,    // [0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [6:0] out_byte, [8:7] status, [13:9] line_length, [15:14] zero
  output logic [15:0]                    m_tdata,
  output logic [1:0]                     m_tuser,    // [1:0] out_kind
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lewt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lewt_pkg::TMO_W-1:0]     cfg_data
);

  lewt_pkg::cmd_t  cmd;
  lewt_pkg::stat_t st;

  logic [1:0]                  out_status;
  logic [lewt_pkg::LEN_W-1:0]  out_len;
  logic [lewt_pkg::CHAR_W-1:0] out_byte;

  lewt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lewt_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (s_tuser),
    .in_char_d  (s_tdata[lewt_pkg::CHAR_W-1:0]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_len    (out_len),
    .out_last   (m_tlast)
  );

  // Result fields packed from the lowest bit up, padded to two bytes.
  assign m_tdata = {2'b00, out_len, out_status, out_byte};

endmodule
